// ===== hw/rtl/ckx_pkg.sv =====
// Shared types and constants for the ChaCha keystream XOR unit.
// Holds the sigma words, register indexes, the block set-up struct and the state enums.
// No dependencies.
package ckx_pkg;

  localparam logic [31:0] SIGMA_WORD0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_WORD1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_WORD2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_WORD3 = 32'h6b20_6574;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned TDATA_W     = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_01     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_23     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_45     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_67     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CTR_NONCE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HI   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUNDS     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_ORDER = 3'd7;

  // Everything the block function needs to build its initial state.
  typedef struct packed {
    logic [7:0][31:0] key;
    logic [31:0]      counter;
    logic [2:0][31:0] nonce;
    logic [3:0]       double_rounds;
  } blk_cfg_t;

  // The four add, xor and rotate steps of one quarter round.
  typedef enum logic [1:0] {
    QR_STEP_A,
    QR_STEP_B,
    QR_STEP_C,
    QR_STEP_D
  } qr_step_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD,
    CORE_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_GEN,
    TOP_EMIT
  } top_state_t;

endpackage

// ===== hw/rtl/ckx_qr_lane.sv =====
// One lane of the shared quarter-round unit: a single add, xor and rotate step.
// Depends on ckx_pkg for the step code.
module ckx_qr_lane (
  input  ckx_pkg::qr_step_t step,
  input  logic [31:0]       x,
  input  logic [31:0]       y,
  input  logic [31:0]       z,
  output logic [31:0]       x_out,
  output logic [31:0]       z_out
);

  logic [31:0] mix;

  assign x_out = x + y;
  assign mix   = z ^ x_out;

  always_comb begin
    unique case (step)
      ckx_pkg::QR_STEP_A: z_out = {mix[15:0], mix[31:16]};
      ckx_pkg::QR_STEP_B: z_out = {mix[19:0], mix[31:20]};
      ckx_pkg::QR_STEP_C: z_out = {mix[23:0], mix[31:24]};
      ckx_pkg::QR_STEP_D: z_out = {mix[24:0], mix[31:25]};
    endcase
  end

endmodule

// ===== hw/rtl/ckx_core.sv =====
// ChaCha block function: sixteen state words, four quarter-round lanes and their sequencer.
// Depends on ckx_pkg and ckx_qr_lane.
module ckx_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  ckx_pkg::blk_cfg_t cfg,
  output logic              done,
  output logic [15:0][31:0] words
);

  ckx_pkg::core_state_t state, state_next;
  ckx_pkg::qr_step_t    step;
  logic                 diag;
  logic [3:0]           dr_cnt;
  logic                 last_step;

  logic [15:0][31:0] init;
  logic [15:0][31:0] w_round;
  logic [3:0][31:0]  a_in, b_in, c_in, d_in;
  logic [3:0][31:0]  x_in, y_in, z_in, x_res, z_res;
  logic [3:0][31:0]  a_new, b_new, c_new, d_new;

  assign init = {cfg.nonce, cfg.counter, cfg.key, ckx_pkg::SIGMA_WORD3, ckx_pkg::SIGMA_WORD2,
                 ckx_pkg::SIGMA_WORD1, ckx_pkg::SIGMA_WORD0};

  // Lane j works on column j, or in a diagonal round on the diagonal that starts at word j.
  // Even steps update a and d, odd steps update c and b.
  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int unsigned GB = (j + 1) % 4;
    localparam int unsigned GC = (j + 2) % 4;
    localparam int unsigned GD = (j + 3) % 4;

    assign a_in[j] = words[j];
    assign b_in[j] = diag ? words[4 + GB]  : words[4 + j];
    assign c_in[j] = diag ? words[8 + GC]  : words[8 + j];
    assign d_in[j] = diag ? words[12 + GD] : words[12 + j];

    assign x_in[j] = step[0] ? c_in[j] : a_in[j];
    assign y_in[j] = step[0] ? d_in[j] : b_in[j];
    assign z_in[j] = step[0] ? b_in[j] : d_in[j];

    ckx_qr_lane u_lane (
      .step  (step),
      .x     (x_in[j]),
      .y     (y_in[j]),
      .z     (z_in[j]),
      .x_out (x_res[j]),
      .z_out (z_res[j])
    );

    assign a_new[j] = step[0] ? a_in[j]  : x_res[j];
    assign b_new[j] = step[0] ? z_res[j] : b_in[j];
    assign c_new[j] = step[0] ? x_res[j] : c_in[j];
    assign d_new[j] = step[0] ? d_in[j]  : z_res[j];

    // Word j of each row goes back from the lane that read it.
    assign w_round[j]      = a_new[j];
    assign w_round[4 + j]  = diag ? b_new[GD] : b_new[j];
    assign w_round[8 + j]  = diag ? c_new[GC] : c_new[j];
    assign w_round[12 + j] = diag ? d_new[GB] : d_new[j];
  end

  assign last_step = (step == ckx_pkg::QR_STEP_D) && diag &&
                     (({1'b0, dr_cnt} + 5'd1) == {1'b0, cfg.double_rounds});

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ckx_pkg::CORE_IDLE;
      step   <= ckx_pkg::QR_STEP_A;
      diag   <= 1'b0;
      dr_cnt <= 4'd0;
    end else begin
      state <= state_next;
      if (state == ckx_pkg::CORE_ROUND) begin
        step <= ckx_pkg::qr_step_t'(step + 2'd1);
        if (step == ckx_pkg::QR_STEP_D) begin
          diag <= ~diag;
          if (diag) begin
            dr_cnt <= dr_cnt + 4'd1;
          end
        end
      end else begin
        step   <= ckx_pkg::QR_STEP_A;
        diag   <= 1'b0;
        dr_cnt <= 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ckx_pkg::CORE_IDLE: begin
        if (go) begin
          words <= init;
        end
      end
      ckx_pkg::CORE_ROUND: begin
        words <= w_round;
      end
      ckx_pkg::CORE_ADD: begin
        for (int i = 0; i < 16; i++) begin
          words[i] <= words[i] + init[i];
        end
      end
      ckx_pkg::CORE_DONE: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      ckx_pkg::CORE_IDLE: begin
        if (go) begin
          state_next = (cfg.double_rounds == 4'd0) ? ckx_pkg::CORE_ADD : ckx_pkg::CORE_ROUND;
        end
      end
      ckx_pkg::CORE_ROUND: begin
        if (last_step) begin
          state_next = ckx_pkg::CORE_ADD;
        end
      end
      ckx_pkg::CORE_ADD: begin
        state_next = ckx_pkg::CORE_DONE;
      end
      ckx_pkg::CORE_DONE: begin
        state_next = ckx_pkg::CORE_IDLE;
        done       = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/chacha_keystream_xor_unit.sv =====
// ChaCha keystream XOR unit: XORs a stream of 32-bit little-endian words with ChaCha keystream.
// Depends on ckx_pkg and ckx_core.
//
// One word is taken at a time. A word that falls inside a keystream block already made is
// accepted, then its result is formed. The first word of a message (tuser set) and the word
// after every sixteenth wait for the block function to run first: it loads its initial
// state, then four quarter-round lanes each do one add, xor and rotate step per cycle through
// floor(round_count / 2) double rounds, then come the final addition and the copy into the
// keystream store. The result register lets the next word be taken while a result still
// waits on m_tready.
module chacha_keystream_xor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // data_in [31:0], valid_bytes [34:32], zero padding [39:35]
  input  logic [ckx_pkg::TDATA_W-1:0]         s_tdata,
  // start_req [0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // data_out [31:0], valid_bytes_out [34:32], zero padding [39:35]
  output logic [ckx_pkg::TDATA_W-1:0]         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ckx_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ckx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ckx_pkg::top_state_t state, state_next;

  logic [63:0] key_01, key_23, key_45, key_67;
  logic [63:0] ctr_nonce_lo, nonce_hi, word_order;
  logic [3:0]  dbl_rounds;

  logic [31:0] block_counter;
  logic [3:0]  word_position;
  logic        block_ready;

  logic [31:0] ks [16];
  logic [31:0] data_reg, out_data;
  logic [2:0]  vb_reg, out_vb;

  logic              in_accept, need_block, core_go, core_done, out_free, emit;
  ckx_pkg::blk_cfg_t blk_cfg;
  logic [15:0][31:0] core_words;

  function automatic logic [31:0] byte_mask(input logic [2:0] count);
    logic [31:0] mask;
    unique case (count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    return mask;
  endfunction

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ckx_pkg::TOP_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign need_block = s_tuser || !block_ready;
  assign core_go    = in_accept && need_block;
  assign out_free   = !m_tvalid || m_tready;
  assign emit       = (state == ckx_pkg::TOP_EMIT) && out_free;
  assign m_tdata    = {5'd0, out_vb, out_data};

  // A start word loads the counter in the same edge as the core takes its initial state.
  always_comb begin
    blk_cfg.key           = {key_67, key_45, key_23, key_01};
    blk_cfg.counter       = (in_accept && s_tuser) ? ctr_nonce_lo[31:0] : block_counter;
    blk_cfg.nonce         = {nonce_hi, ctr_nonce_lo[63:32]};
    blk_cfg.double_rounds = dbl_rounds;
  end

  ckx_core u_core (
    .clk   (clk),
    .rst   (rst),
    .go    (core_go),
    .cfg   (blk_cfg),
    .done  (core_done),
    .words (core_words)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_01       <= 64'd0;
      key_23       <= 64'd0;
      key_45       <= 64'd0;
      key_67       <= 64'd0;
      ctr_nonce_lo <= 64'd0;
      nonce_hi     <= 64'd0;
      dbl_rounds   <= 4'd10;
      word_order   <= 64'hfedc_ba98_7654_3210;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ckx_pkg::REG_KEY_01:     key_01       <= cfg_data;
        ckx_pkg::REG_KEY_23:     key_23       <= cfg_data;
        ckx_pkg::REG_KEY_45:     key_45       <= cfg_data;
        ckx_pkg::REG_KEY_67:     key_67       <= cfg_data;
        ckx_pkg::REG_CTR_NONCE:  ctr_nonce_lo <= cfg_data;
        ckx_pkg::REG_NONCE_HI:   nonce_hi     <= cfg_data;
        ckx_pkg::REG_ROUNDS:     dbl_rounds   <= cfg_data[4:1];
        ckx_pkg::REG_WORD_ORDER: word_order   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckx_pkg::TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ckx_pkg::TOP_IDLE: begin
        if (in_accept) begin
          state_next = need_block ? ckx_pkg::TOP_GEN : ckx_pkg::TOP_EMIT;
        end
      end
      ckx_pkg::TOP_GEN: begin
        if (core_done) begin
          state_next = ckx_pkg::TOP_EMIT;
        end
      end
      ckx_pkg::TOP_EMIT: begin
        if (out_free) begin
          state_next = ckx_pkg::TOP_IDLE;
        end
      end
      default: state_next = ckx_pkg::TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= 32'd0;
      word_position <= 4'd0;
      block_ready   <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_accept && s_tuser) begin
        block_counter <= ctr_nonce_lo[31:0];
        word_position <= 4'd0;
        block_ready   <= 1'b0;
      end
      if (core_done) begin
        block_counter <= block_counter + 32'd1;
        block_ready   <= 1'b1;
      end
      if (emit) begin
        word_position <= word_position + 4'd1;
        // The sixteenth word uses up the block.
        if (word_position == 4'hf) begin
          block_ready <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_reg <= s_tdata[31:0];
      vb_reg   <= s_tdata[34:32];
    end
    if (core_done) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= core_words[word_order[4*i +: 4]];
      end
    end
    if (emit) begin
      out_data <= (data_reg ^ ks[word_position]) & byte_mask(vb_reg);
      out_vb   <= vb_reg;
    end
  end

  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    core_done |-> state == ckx_pkg::TOP_GEN)
    else $error("block function finished while no word was waiting for it");

  a_emit_has_block: assert property (@(posedge clk) disable iff (rst)
    state == ckx_pkg::TOP_EMIT |-> block_ready)
    else $error("result formed without a keystream block");

  a_go_waits: assert property (@(posedge clk) disable iff (rst)
    core_go |=> state == ckx_pkg::TOP_GEN)
    else $error("block function started but the word did not wait for it");

  a_start_resets_pos: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tuser |=> word_position == 4'd0)
    else $error("start word did not restart the keystream position");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("result register not loaded");

endmodule
